// ----- rtl/tsq_pkg.sv -----
// Shared types and constants for the sorted timer queue.
// Used by the entry store, the output register and the top level.
`timescale 1ns / 1ps

package tsq_pkg;

  localparam int TimeBits   = 32;
  localparam int TagBits    = 16;
  localparam int PendBits   = 5;
  localparam int MaxResults = 16;
  localparam int NumBits    = $clog2(MaxResults + 1);

  localparam logic KIND_SCHEDULE = 1'b0;
  localparam logic KIND_FIRE     = 1'b1;

  typedef struct packed {
    logic                kind;
    logic [TimeBits-1:0] deadline;
    logic [TagBits-1:0]  tag;
    logic [TimeBits-1:0] now;
  } in_item_t;

  typedef struct packed {
    logic                fired;
    logic [TagBits-1:0]  fired_tag;
    logic [TimeBits-1:0] fired_deadline;
    logic                last;
    logic                full_drop;
    logic [PendBits-1:0] pending;
    logic [TimeBits-1:0] earliest;
  } out_item_t;

  typedef struct packed {
    logic [TimeBits-1:0] deadline;
    logic [TagBits-1:0]  tag;
  } entry_t;

  typedef struct packed {
    logic   we;
    entry_t data;
  } store_wr_t;

endpackage

// ----- rtl/tsq_store.sv -----
// Entry store of the timer queue: one write port and one registered read port.
// Depends on tsq_pkg for the entry and write-request types.
`timescale 1ns / 1ps

module tsq_store
  import tsq_pkg::*;
#(
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  store_wr_t                wr,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output entry_t                   rdata
);

  entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr.we) begin
      mem[waddr] <= wr.data;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/tsq_outreg.sv -----
// Output register of the timer queue; holds one result item until it is taken.
// Depends on tsq_pkg for the result item type.
`timescale 1ns / 1ps

module tsq_outreg
  import tsq_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      load,
  input  out_item_t load_item,
  output logic      free,
  output logic      valid,
  input  logic      stall,
  output out_item_t item
);

  assign free = !valid || !stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (free) begin
      valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (free && load) begin
      item <= load_item;
    end
  end

endmodule

// ----- rtl/deadline_sorted_timer_queue_unit.sv -----
// Sorted timer queue: up to DEPTH timers kept in ascending deadline order in
// a circular store, with the earliest timer mirrored in registers.
// Depends on tsq_pkg, tsq_store and tsq_outreg.
`timescale 1ns / 1ps

// A schedule item walks back from the tail one entry at a time through one
// shared comparator (read, then compare), moving later timers up a slot, and
// then loads its result; a dropped schedule goes straight to its result. A fire
// item goes through compare, head read and result for each expired timer, with
// no head read for the timer that empties the table, and through compare and
// result alone when nothing has expired. The input is stalled for the whole
// item, and each result waits in an output register until it is taken.
module deadline_sorted_timer_queue_unit
  import tsq_pkg::*;
#(
  parameter int DEPTH = 16
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_item,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_item
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_IRD  = 6'b000010,
    S_ICMP = 6'b000100,
    S_FCHK = 6'b001000,
    S_FRD  = 6'b010000,
    S_EMIT = 6'b100000
  } state_t;

  state_t              state;
  logic [PW-1:0]       head;
  logic [PW-1:0]       ptr;
  logic [CW-1:0]       count;
  logic [CW-1:0]       remain;
  logic [NumBits-1:0]  num;
  entry_t              new_entry;
  logic [TimeBits-1:0] now_r;
  entry_t              hd;
  logic                res_fired;
  logic                res_drop;
  entry_t              res_entry;

  store_wr_t           wr;
  logic [PW-1:0]       waddr;
  logic [PW-1:0]       raddr;
  entry_t              rdata;

  logic [TimeBits-1:0] cmp_a;
  logic [TimeBits-1:0] cmp_b;
  logic                cmp_le;
  logic                expire;
  logic                emit_last;
  logic                out_free;
  logic                out_load;
  out_item_t           load_item;
  logic [PW:0]         tail_sum;
  logic [PW-1:0]       tail;

  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    ptr_inc = (p == PW'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  function automatic logic [PW-1:0] ptr_dec(input logic [PW-1:0] p);
    ptr_dec = (p == '0) ? PW'(DEPTH - 1) : p - 1'b1;
  endfunction

  assign tail_sum = {1'b0, head} + (PW + 1)'(count);
  assign tail     = (tail_sum >= (PW + 1)'(DEPTH)) ? PW'(tail_sum - (PW + 1)'(DEPTH))
                                                   : tail_sum[PW-1:0];

  // One comparator serves both the insertion walk and the expiry check.
  assign cmp_a  = (state == S_ICMP) ? rdata.deadline : hd.deadline;
  assign cmp_b  = (state == S_ICMP) ? new_entry.deadline : now_r;
  assign cmp_le = cmp_a <= cmp_b;
  assign expire = (count != '0) && cmp_le && (num < NumBits'(MaxResults));

  assign emit_last = res_fired ? !expire : 1'b1;
  assign in_stall  = (state != S_IDLE);
  assign out_load  = (state == S_EMIT);

  always_comb begin
    load_item                = '0;
    load_item.fired          = res_fired;
    load_item.fired_tag      = res_entry.tag;
    load_item.fired_deadline = res_entry.deadline;
    load_item.last           = emit_last;
    load_item.full_drop      = res_drop;
    load_item.pending        = PendBits'(count);
    load_item.earliest       = (count != '0) ? hd.deadline : '0;
  end

  always_comb begin
    wr.we   = 1'b0;
    wr.data = new_entry;
    waddr   = ptr;
    raddr   = ptr_dec(ptr);
    case (state)
      S_IRD: begin
        wr.we = (remain == '0);
      end
      S_ICMP: begin
        wr.we = 1'b1;
        if (!cmp_le) begin
          wr.data = rdata;
        end
      end
      S_FCHK: begin
        raddr = ptr_inc(head);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      head  <= '0;
      count <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            new_entry.deadline <= in_item.deadline;
            new_entry.tag      <= in_item.tag;
            now_r              <= in_item.now;
            num                <= '0;
            res_fired          <= 1'b0;
            res_drop           <= 1'b0;
            res_entry          <= '0;
            ptr                <= tail;
            remain             <= count;
            if (in_item.kind == KIND_FIRE) begin
              state <= S_FCHK;
            end else if (count == CW'(DEPTH)) begin
              res_drop <= 1'b1;
              state    <= S_EMIT;
            end else begin
              state <= S_IRD;
            end
          end
        end
        S_IRD: begin
          if (remain == '0) begin
            hd    <= new_entry;
            count <= count + 1'b1;
            state <= S_EMIT;
          end else begin
            state <= S_ICMP;
          end
        end
        S_ICMP: begin
          if (!cmp_le) begin
            ptr    <= ptr_dec(ptr);
            remain <= remain - 1'b1;
            state  <= S_IRD;
          end else begin
            count <= count + 1'b1;
            state <= S_EMIT;
          end
        end
        S_FCHK: begin
          if (expire) begin
            res_fired <= 1'b1;
            res_entry <= hd;
            head      <= ptr_inc(head);
            count     <= count - 1'b1;
            num       <= num + 1'b1;
            state     <= (count > CW'(1)) ? S_FRD : S_EMIT;
          end else begin
            state <= S_EMIT;
          end
        end
        S_FRD: begin
          hd    <= rdata;
          state <= S_EMIT;
        end
        S_EMIT: begin
          if (out_free) begin
            state <= emit_last ? S_IDLE : S_FCHK;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  tsq_store #(
    .DEPTH(DEPTH)
  ) u_store (
    .clk  (clk),
    .wr   (wr),
    .waddr(waddr),
    .raddr(raddr),
    .rdata(rdata)
  );

  tsq_outreg u_outreg (
    .clk      (clk),
    .rst      (rst),
    .load     (out_load),
    .load_item(load_item),
    .free     (out_free),
    .valid    (out_valid),
    .stall    (out_stall),
    .item     (out_item)
  );

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("pending count exceeds the table depth");

  a_drop_shape: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.full_drop |-> out_item.last && !out_item.fired)
    else $error("dropped schedule result is malformed");

  a_fire_order: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && out_item.fired && !out_item.last && out_item.pending != '0
    |-> out_item.earliest >= out_item.fired_deadline)
    else $error("fired timers leave out of deadline order");

  a_walk_single_write: assert property (@(posedge clk) disable iff (rst)
    wr.we |-> (state == S_IRD || state == S_ICMP))
    else $error("store written outside an insertion");
`endif

endmodule

// ----- verif/deadline_sorted_timer_queue_unit_tb.sv -----
// Testbench for the sorted timer queue: directed corner cases, overflow bursts
// and random schedule/fire traffic, checked against an in-bench shadow queue.
// Depends on tsq_pkg and deadline_sorted_timer_queue_unit.
`timescale 1ns / 1ps

module deadline_sorted_timer_queue_unit_tb;
  import tsq_pkg::*;

  localparam int Depth = 16;
  localparam int QuietLimit = 1000;
  localparam int DrainCycles = 80;
  localparam logic [TimeBits-1:0] TimeMax = '1;

  logic      clk;
  logic      rst;
  logic      in_valid;
  logic      in_stall;
  in_item_t  in_item;
  logic      out_valid;
  logic      out_stall;
  out_item_t out_item;

  logic [TimeBits-1:0] shadow_deadline [Depth];
  logic [TagBits-1:0]  shadow_tag [Depth];
  int                  shadow_count;
  out_item_t           timer_results_due [$];
  logic [TimeBits-1:0] wall_time;
  bit                  tx_idle;
  bit                  rx_idle;
  int                  mismatches;
  int                  quiet_cycles;

  deadline_sorted_timer_queue_unit #(
    .DEPTH(Depth)
  ) u_dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_item (out_item)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  function automatic int gap_len(input bit enabled);
    int r;
    r = $urandom_range(0, 99);
    if (!enabled || r < 60) begin
      return 0;
    end else if (r < 92) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 40);
  endfunction

  function automatic out_item_t make_result(input logic fired, input logic [TagBits-1:0] tg,
                                            input logic [TimeBits-1:0] dl, input logic last,
                                            input logic drop);
    out_item_t r;
    r.fired          = fired;
    r.fired_tag      = tg;
    r.fired_deadline = dl;
    r.last           = last;
    r.full_drop      = drop;
    r.pending        = PendBits'(shadow_count);
    r.earliest       = (shadow_count > 0) ? shadow_deadline[0] : '0;
    return r;
  endfunction

  // Updates the shadow queue with one accepted item and queues its results.
  task automatic shadow_apply(input in_item_t item);
    int                  pos;
    int                  n;
    bit                  more;
    logic [TimeBits-1:0] dl;
    logic [TagBits-1:0]  tg;
    if (item.kind == KIND_SCHEDULE) begin
      if (shadow_count >= Depth) begin
        timer_results_due.push_back(make_result(1'b0, '0, '0, 1'b1, 1'b1));
      end else begin
        pos = 0;
        while (pos < shadow_count && shadow_deadline[pos] <= item.deadline) pos++;
        for (int i = shadow_count; i > pos; i--) begin
          shadow_deadline[i] = shadow_deadline[i-1];
          shadow_tag[i]      = shadow_tag[i-1];
        end
        shadow_deadline[pos] = item.deadline;
        shadow_tag[pos]      = item.tag;
        shadow_count++;
        timer_results_due.push_back(make_result(1'b0, '0, '0, 1'b1, 1'b0));
      end
    end else begin
      n = 0;
      more = shadow_count > 0 && shadow_deadline[0] <= item.now;
      if (!more) begin
        timer_results_due.push_back(make_result(1'b0, '0, '0, 1'b1, 1'b0));
      end
      while (more) begin
        dl = shadow_deadline[0];
        tg = shadow_tag[0];
        for (int i = 1; i < shadow_count; i++) begin
          shadow_deadline[i-1] = shadow_deadline[i];
          shadow_tag[i-1]      = shadow_tag[i];
        end
        shadow_count--;
        n++;
        more = n < MaxResults && shadow_count > 0 && shadow_deadline[0] <= item.now;
        timer_results_due.push_back(make_result(1'b1, tg, dl, !more, 1'b0));
      end
    end
  endtask

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_item(input in_item_t item);
    int g;
    g = gap_len(tx_idle);
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= item;
    do @(posedge clk); while (in_stall);
    shadow_apply(item);
    @(negedge clk);
  endtask

  task automatic send_schedule(input logic [TimeBits-1:0] dl, input logic [TagBits-1:0] tg);
    in_item_t item;
    item.kind     = KIND_SCHEDULE;
    item.deadline = dl;
    item.tag      = tg;
    item.now      = $urandom;
    send_item(item);
  endtask

  task automatic send_fire(input logic [TimeBits-1:0] now);
    in_item_t item;
    item.kind     = KIND_FIRE;
    item.deadline = $urandom;
    item.tag      = TagBits'($urandom);
    item.now      = now;
    send_item(item);
  endtask

  task automatic test_directed();
    tx_idle = 1'b1;
    rx_idle = 1'b1;
    send_fire(TimeMax);
    send_schedule(TimeMax, 16'hFFFF);
    send_schedule('0, '0);
    send_schedule(32'd5, 16'd1);
    send_schedule(32'd5, 16'd2);
    send_fire(32'd4);
    send_fire('0);
    send_schedule(TimeMax, 16'h1234);
    send_schedule(32'd5, 16'd3);
    send_schedule(32'h8000_0000, 16'h8000);
    send_schedule(32'h7FFF_FFFF, 16'h7FFF);
    send_schedule(32'd1, 16'd4);
    for (int i = 0; i < 8; i++) begin
      send_schedule($urandom, TagBits'($urandom));
    end
    send_schedule($urandom, TagBits'($urandom));
    send_schedule(32'd2, 16'd5);
    send_fire(32'd5);
    send_fire(TimeMax);
  endtask

  task automatic test_overflow_bursts(input int rounds);
    logic [TimeBits-1:0] base;
    int                  n;
    for (int r = 0; r < rounds; r++) begin
      tx_idle = r[0];
      rx_idle = r[0];
      base = $urandom;
      n = $urandom_range(16, 20);
      for (int k = 0; k < n; k++) begin
        send_schedule(base + $urandom_range(0, 15), TagBits'($urandom));
      end
      send_fire(base + $urandom_range(0, 15));
      send_fire(TimeMax);
    end
  endtask

  task automatic test_random_traffic(input int items, input bit idle);
    int                  r;
    int                  pick;
    logic [TimeBits-1:0] dl;
    tx_idle = idle;
    rx_idle = idle;
    wall_time = $urandom;
    for (int i = 0; i < items; i++) begin
      r = $urandom_range(0, 99);
      if (r < 55) begin
        pick = $urandom_range(0, 9);
        dl = $urandom;
        if (pick < 6) begin
          dl = wall_time + $urandom_range(0, 300);
        end else if (pick == 6 && shadow_count > 0) begin
          dl = shadow_deadline[$urandom_range(0, shadow_count - 1)];
        end else if (pick == 7) begin
          dl = wall_time;
        end
        send_schedule(dl, TagBits'($urandom));
      end else if (r < 93) begin
        wall_time = wall_time + $urandom_range(0, 150);
        send_fire(wall_time);
      end else if (r < 97) begin
        send_fire($urandom);
      end else begin
        send_fire(TimeMax);
      end
    end
  endtask

  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    out_item_t want;
    if (!rst && out_valid && !out_stall) begin
      if (timer_results_due.size() == 0) begin
        $error("result with no expectation waiting: %p", out_item);
        mismatches++;
      end else begin
        want = timer_results_due.pop_front();
        check_field("fired", 32'(want.fired), 32'(out_item.fired));
        check_field("fired_tag", 32'(want.fired_tag), 32'(out_item.fired_tag));
        check_field("fired_deadline", want.fired_deadline, out_item.fired_deadline);
        check_field("last", 32'(want.last), 32'(out_item.last));
        check_field("full_drop", 32'(want.full_drop), 32'(out_item.full_drop));
        check_field("pending", 32'(want.pending), 32'(out_item.pending));
        check_field("earliest", want.earliest, out_item.earliest);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QuietLimit) begin
      $display("deadline_sorted_timer_queue_unit_tb: FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int g;
    out_stall = 1'b0;
    @(negedge rst);
    forever begin
      @(negedge clk);
      g = gap_len(rx_idle);
      if (g > 0) begin
        out_stall <= 1'b1;
        repeat (g) @(negedge clk);
      end
      out_stall <= 1'b0;
      repeat ($urandom_range(0, 5)) @(negedge clk);
    end
  end

  initial begin
    rst          = 1'b1;
    in_valid     = 1'b0;
    in_item      = '0;
    shadow_count = 0;
    mismatches   = 0;
    quiet_cycles = 0;
    tx_idle      = 1'b0;
    rx_idle      = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    test_directed();
    test_overflow_bursts(5);
    test_random_traffic(150, 1'b1);
    test_random_traffic(100, 1'b0);
    test_random_traffic(110, 1'b1);
    in_valid <= 1'b0;
    while (timer_results_due.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (mismatches == 0) begin
      $display("deadline_sorted_timer_queue_unit_tb: PASS");
    end else begin
      $display("deadline_sorted_timer_queue_unit_tb: FAIL");
    end
    $finish;
  end

endmodule

// ----- deadline_sorted_timer_queue_unit.f -----
rtl/tsq_pkg.sv
rtl/tsq_store.sv
rtl/tsq_outreg.sv
rtl/deadline_sorted_timer_queue_unit.sv
verif/deadline_sorted_timer_queue_unit_tb.sv
